// ===== design/etl_pkg.sv =====
// Shared types and constants of the event trace logger.
package etl_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = 8;
  localparam int CNT_W       = 9;

  localparam logic [1:0] OP_EMIT  = 2'd0;
  localparam logic [1:0] OP_DROP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_REPEAT  = 2'd2;

  localparam logic [1:0] CFG_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_STARTUP   = 2'd2;
  localparam logic [1:0] CFG_INVERSION = 2'd3;

  localparam logic [31:0] WINDOW_RST    = 32'd100;
  localparam logic [7:0]  STARTUP_RST   = 8'd1;
  localparam logic [7:0]  INVERSION_RST = 8'd255;

  typedef struct packed {
    logic [3:0]        module_id;
    logic signed [7:0] task_id;
    logic [7:0]        event_code;
    logic [31:0]       time_ms;
  } entry_t;

  typedef struct packed {
    logic [7:0]  last_code;
    logic [31:0] last_time;
    logic [7:0]  highest_code;
    logic        inversion_seen;
  } mod_state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        appended;
    logic              inversion_flag;
    logic              overflow_cleared;
    logic [8:0]        dropped;
    logic [8:0]        entry_count;
    logic              read_valid;
    logic [3:0]        read_module;
    logic signed [7:0] read_task;
    logic [7:0]        read_event;
    logic [31:0]       read_time;
  } result_t;

endpackage

// ===== design/event_trace_logger_unit.sv =====
// Top level of the event trace logger: ring log plus per-module state in RAM.
//
//  channel | ports                          | handshake
//  in      | in_op .. in_read_offset        | start & !busy
//  out     | out_status .. out_read_time    | out_valid, one cycle, no stall
//  cfg     | cfg_we, cfg_index, cfg_wdata   | cfg_we, immediate
//
// Emit and read are answered from S_EXEC; an emit that adds an inversion
// entry writes it in S_PUSH2 first. Clear answers in the cycle after start.
// Drop stays in S_EXEC, one log RAM read per cycle walking from the oldest end.
// Reset (synchronous) empties the log and per-module state at once through
// valid bits; the log RAM itself is never cleared. Results cannot be stalled.
module event_trace_logger_unit #(
  parameter int LOG_LIMIT    = 254,
  parameter int MODULE_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [3:0]        in_module_id,
  input  logic signed [7:0] in_task_id,
  input  logic [7:0]        in_event_code,
  input  logic [31:0]       in_time_ms,
  input  logic [7:0]        in_read_offset,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [1:0]        out_appended,
  output logic              out_inversion_flag,
  output logic              out_overflow_cleared,
  output logic [8:0]        out_dropped,
  output logic [8:0]        out_entry_count,
  output logic              out_read_valid,
  output logic [3:0]        out_read_module,
  output logic signed [7:0] out_read_task,
  output logic [7:0]        out_read_event,
  output logic [31:0]       out_read_time,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);

  localparam int MW = $clog2(MODULE_COUNT);
  localparam int LW = 13;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_PUSH2 = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [3:0]  mod_r, mod_nxt;
  logic signed [7:0] task_r, task_nxt;
  logic [7:0]  event_r, event_nxt;
  logic [31:0] time_r, time_nxt;
  logic [7:0]  offset_r, offset_nxt;
  logic [MW-1:0] midx_r, midx_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [7:0]  oldest_r, oldest_nxt;
  logic [8:0]  ndrop_r, ndrop_nxt;
  logic [MODULE_COUNT-1:0] mvalid_r, mvalid_nxt;
  logic        en_r;
  logic [31:0] win_r;
  logic [7:0]  startup_r;
  logic [7:0]  invc_r;
  logic        out_valid_r, out_valid_nxt;
  etl_pkg::result_t res_r, res_nxt;

  logic [6:0]    mod_tmp;
  logic [MW-1:0] midx_in;
  logic [MW-1:0] mram_raddr;

  logic                  log_we;
  logic [7:0]            log_waddr, log_raddr;
  etl_pkg::entry_t       log_wdata, log_rdata;
  logic                  mram_we;
  etl_pkg::mod_state_t   mram_wdata, mram_rdata, mstate, mnew;

  logic       ovf, rep, inv;
  logic [8:0] cnt_e;
  logic [7:0] old_e;

  etl_ram #(.WIDTH($bits(etl_pkg::entry_t)), .DEPTH(etl_pkg::STORE_DEPTH)) u_log_ram (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .raddr (log_raddr),
    .rdata (log_rdata)
  );

  etl_ram #(.WIDTH($bits(etl_pkg::mod_state_t)), .DEPTH(MODULE_COUNT)) u_mod_ram (
    .clk   (clk),
    .we    (mram_we),
    .waddr (midx_r),
    .wdata (mram_wdata),
    .raddr (mram_raddr),
    .rdata (mram_rdata)
  );

  always_comb begin
    mod_tmp = {3'd0, in_module_id};
    for (int i = 0; i < 8; i++) begin
      if (mod_tmp >= 7'(MODULE_COUNT)) begin
        mod_tmp = mod_tmp - 7'(MODULE_COUNT);
      end
    end
    midx_in = mod_tmp[MW-1:0];
  end

  assign mram_raddr = (state_r == S_IDLE) ? midx_in : midx_r;

  assign mstate = mvalid_r[midx_r] ? mram_rdata : '0;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    mod_nxt       = mod_r;
    task_nxt      = task_r;
    event_nxt     = event_r;
    time_nxt      = time_r;
    offset_nxt    = offset_r;
    midx_nxt      = midx_r;
    cnt_nxt       = cnt_r;
    oldest_nxt    = oldest_r;
    ndrop_nxt     = ndrop_r;
    mvalid_nxt    = mvalid_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    log_we        = 1'b0;
    log_waddr     = oldest_r + cnt_r[7:0];
    log_wdata     = '{mod_r, task_r, invc_r, time_r};
    log_raddr     = oldest_r;
    mram_we       = 1'b0;
    mram_wdata    = mstate;
    mnew          = mstate;
    ovf           = 1'b0;
    rep           = 1'b0;
    inv           = 1'b0;
    cnt_e         = cnt_r;
    old_e         = oldest_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_op;
          mod_nxt    = in_module_id;
          task_nxt   = in_task_id;
          event_nxt  = in_event_code;
          time_nxt   = in_time_ms;
          offset_nxt = in_read_offset;
          midx_nxt   = midx_in;
          ndrop_nxt  = '0;
          if (in_op == etl_pkg::OP_READ) begin
            log_raddr = oldest_r + in_read_offset;
          end
          if (in_op == etl_pkg::OP_CLEAR) begin
            res_nxt         = '0;
            res_nxt.dropped = cnt_r;
            cnt_nxt         = '0;
            oldest_nxt      = '0;
            mvalid_nxt      = '0;
            out_valid_nxt   = 1'b1;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        res_nxt                = '0;
        res_nxt.inversion_flag = mstate.inversion_seen;
        res_nxt.entry_count    = cnt_r;
        unique case (op_r)
          etl_pkg::OP_EMIT: begin
            if (!en_r) begin
              res_nxt.status = etl_pkg::ST_IGNORED;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              ovf   = ({4'd0, cnt_r} > LW'(LOG_LIMIT)) ||
                      (cnt_r >= 9'(etl_pkg::STORE_DEPTH - 1));
              cnt_e = ovf ? '0 : cnt_r;
              old_e = ovf ? '0 : oldest_r;
              rep   = (mstate.last_code == event_r) &&
                      ((time_r - mstate.last_time) < win_r);
              inv   = !((event_r >= mstate.highest_code) || (event_r == startup_r));
              res_nxt.overflow_cleared = ovf;
              res_nxt.dropped          = ovf ? cnt_r : '0;
              cnt_nxt    = cnt_e;
              oldest_nxt = old_e;
              if (rep) begin
                res_nxt.status      = etl_pkg::ST_REPEAT;
                res_nxt.entry_count = cnt_e;
                out_valid_nxt       = 1'b1;
                state_nxt           = S_IDLE;
              end else begin
                if (!inv) begin
                  mnew.highest_code   = event_r;
                  mnew.inversion_seen = 1'b0;
                end else begin
                  mnew.inversion_seen = 1'b1;
                end
                mnew.last_code       = event_r;
                mnew.last_time       = time_r;
                mram_we              = 1'b1;
                mram_wdata           = mnew;
                mvalid_nxt[midx_r]   = 1'b1;
                log_we               = 1'b1;
                log_waddr            = old_e + cnt_e[7:0];
                log_wdata            = '{mod_r, task_r, event_r, time_r};
                cnt_nxt              = cnt_e + 9'd1;
                res_nxt.inversion_flag = mnew.inversion_seen;
                res_nxt.appended     = inv ? 2'd2 : 2'd1;
                res_nxt.entry_count  = cnt_e + (inv ? 9'd2 : 9'd1);
                if (inv) begin
                  state_nxt = S_PUSH2;
                end else begin
                  out_valid_nxt = 1'b1;
                  state_nxt     = S_IDLE;
                end
              end
            end
          end
          etl_pkg::OP_DROP: begin
            if ((cnt_r != '0) && (log_rdata.time_ms <= time_r)) begin
              oldest_nxt = oldest_r + 8'd1;
              log_raddr  = oldest_r + 8'd1;
              cnt_nxt    = cnt_r - 9'd1;
              ndrop_nxt  = ndrop_r + 9'd1;
            end else begin
              if (cnt_r == '0) begin
                oldest_nxt = '0;
              end
              res_nxt.dropped = ndrop_r;
              out_valid_nxt   = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
          default: begin
            if ({1'b0, offset_r} < cnt_r) begin
              res_nxt.read_valid  = 1'b1;
              res_nxt.read_module = log_rdata.module_id;
              res_nxt.read_task   = log_rdata.task_id;
              res_nxt.read_event  = log_rdata.event_code;
              res_nxt.read_time   = log_rdata.time_ms;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_PUSH2: begin
        log_we        = 1'b1;
        cnt_nxt       = cnt_r + 9'd1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      oldest_r    <= '0;
      ndrop_r     <= '0;
      mvalid_r    <= '0;
      out_valid_r <= 1'b0;
      en_r        <= 1'b1;
      win_r       <= etl_pkg::WINDOW_RST;
      startup_r   <= etl_pkg::STARTUP_RST;
      invc_r      <= etl_pkg::INVERSION_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      oldest_r    <= oldest_nxt;
      ndrop_r     <= ndrop_nxt;
      mvalid_r    <= mvalid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          etl_pkg::CFG_ENABLE:  en_r      <= cfg_wdata[0];
          etl_pkg::CFG_WINDOW:  win_r     <= cfg_wdata;
          etl_pkg::CFG_STARTUP: startup_r <= cfg_wdata[7:0];
          default:              invc_r    <= cfg_wdata[7:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    mod_r    <= mod_nxt;
    task_r   <= task_nxt;
    event_r  <= event_nxt;
    time_r   <= time_nxt;
    offset_r <= offset_nxt;
    midx_r   <= midx_nxt;
    res_r    <= res_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = res_r.status;
  assign out_appended         = res_r.appended;
  assign out_inversion_flag   = res_r.inversion_flag;
  assign out_overflow_cleared = res_r.overflow_cleared;
  assign out_dropped          = res_r.dropped;
  assign out_entry_count      = res_r.entry_count;
  assign out_read_valid       = res_r.read_valid;
  assign out_read_module      = res_r.read_module;
  assign out_read_task        = res_r.read_task;
  assign out_read_event       = res_r.read_event;
  assign out_read_time        = res_r.read_time;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 9'(etl_pkg::STORE_DEPTH))
    else $error("log count beyond store depth");

  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count == cnt_r)
    else $error("reported count differs from log count");

  a_append_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_appended != 2'd0) |->
      (out_status == etl_pkg::ST_DONE) && !out_read_valid)
    else $error("append reported with non-done status");

endmodule

// ===== design/etl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module etl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the event trace logger unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOG_LIMIT = 254;
  localparam int MODULE_COUNT = 16;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  module_id;
    logic [7:0]  task_id;
    logic [7:0]  event_code;
    logic [31:0] time_ms;
    logic [7:0]  read_offset;
  } trace_cmd_t;

  int error_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  class trace_scoreboard;
    etl_pkg::entry_t  ring [256];
    logic [7:0]       head;
    int               count;
    logic [7:0]       last_code [MODULE_COUNT];
    logic [31:0]      last_time [MODULE_COUNT];
    logic [7:0]       top_code [MODULE_COUNT];
    bit               inv_seen [MODULE_COUNT];
    bit               enable;
    logic [31:0]      window;
    logic [7:0]       startup;
    logic [7:0]       inv_code;
    etl_pkg::result_t pending [$];

    function new();
      head = 0;
      count = 0;
      enable = 1;
      window = etl_pkg::WINDOW_RST;
      startup = etl_pkg::STARTUP_RST;
      inv_code = etl_pkg::INVERSION_RST;
      forget_modules();
    endfunction

    function void forget_modules();
      for (int i = 0; i < MODULE_COUNT; i++) begin
        last_code[i] = 0;
        last_time[i] = 0;
        top_code[i] = 0;
        inv_seen[i] = 0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        etl_pkg::CFG_ENABLE:  enable = val[0];
        etl_pkg::CFG_WINDOW:  window = val;
        etl_pkg::CFG_STARTUP: startup = val[7:0];
        default:              inv_code = val[7:0];
      endcase
    endfunction

    function int trim_upto(logic [31:0] lim);
      int n;
      n = 0;
      while (count > 0 && ring[head].time_ms <= lim) begin
        head++;
        count--;
        n++;
      end
      if (count == 0) head = 0;
      return n;
    endfunction

    function void append(etl_pkg::entry_t e);
      ring[8'(head + count)] = e;
      count++;
    endfunction

    function void note_item(trace_cmd_t c);
      etl_pkg::result_t r;
      int m;
      bit inv;
      etl_pkg::entry_t e;
      r = '0;
      m = c.module_id % MODULE_COUNT;
      case (c.op)
        etl_pkg::OP_EMIT: begin
          if (!enable) begin
            r.status = etl_pkg::ST_IGNORED;
          end else begin
            if (count > LOG_LIMIT || count + 2 > 256) begin
              r.dropped = 9'(trim_upto(32'hFFFF_FFFF));
              r.overflow_cleared = 1;
            end
            if (last_code[m] == c.event_code && (c.time_ms - last_time[m]) < window) begin
              r.status = etl_pkg::ST_REPEAT;
            end else begin
              inv = !(c.event_code >= top_code[m] || c.event_code == startup);
              if (!inv) begin
                top_code[m] = c.event_code;
                inv_seen[m] = 0;
              end
              e = '{c.module_id, c.task_id, c.event_code, c.time_ms};
              append(e);
              last_code[m] = c.event_code;
              last_time[m] = c.time_ms;
              r.appended = 1;
              if (inv) begin
                e.event_code = inv_code;
                append(e);
                inv_seen[m] = 1;
                r.appended = 2;
              end
            end
          end
        end
        etl_pkg::OP_DROP: r.dropped = 9'(trim_upto(c.time_ms));
        etl_pkg::OP_CLEAR: begin
          r.dropped = 9'(count);
          count = 0;
          head = 0;
          forget_modules();
        end
        default: begin
          if (c.read_offset < count) begin
            e = ring[8'(head + c.read_offset)];
            r.read_valid = 1;
            r.read_module = e.module_id;
            r.read_task = e.task_id;
            r.read_event = e.event_code;
            r.read_time = e.time_ms;
          end
        end
      endcase
      r.inversion_flag = inv_seen[m];
      r.entry_count = 9'(count);
      pending.push_back(r);
    endfunction

    task check_result(etl_pkg::result_t got);
      etl_pkg::result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.appended !== want.appended)
        report_mismatch("appended", got.appended, want.appended);
      if (got.inversion_flag !== want.inversion_flag)
        report_mismatch("inversion_flag", got.inversion_flag, want.inversion_flag);
      if (got.overflow_cleared !== want.overflow_cleared)
        report_mismatch("overflow_cleared", got.overflow_cleared, want.overflow_cleared);
      if (got.dropped !== want.dropped) report_mismatch("dropped", got.dropped, want.dropped);
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", got.entry_count, want.entry_count);
      if (got.read_valid !== want.read_valid)
        report_mismatch("read_valid", got.read_valid, want.read_valid);
      if (got.read_module !== want.read_module)
        report_mismatch("read_module", got.read_module, want.read_module);
      if (got.read_task !== want.read_task)
        report_mismatch("read_task", got.read_task, want.read_task);
      if (got.read_event !== want.read_event)
        report_mismatch("read_event", got.read_event, want.read_event);
      if (got.read_time !== want.read_time)
        report_mismatch("read_time", got.read_time, want.read_time);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_op = 0;
  logic [3:0] in_module_id = 0;
  logic signed [7:0] in_task_id = 0;
  logic [7:0] in_event_code = 0;
  logic [31:0] in_time_ms = 0;
  logic [7:0] in_read_offset = 0;
  logic out_valid;
  etl_pkg::result_t seen;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  trace_scoreboard board = new();
  int idle_pct = 0;
  logic [31:0] clock_ms = 0;

  event_trace_logger_unit #(.LOG_LIMIT(LOG_LIMIT), .MODULE_COUNT(MODULE_COUNT)) i_dut (
    .clk, .rst_n, .start, .busy,
    .in_op, .in_module_id, .in_task_id, .in_event_code, .in_time_ms, .in_read_offset,
    .out_valid,
    .out_status(seen.status), .out_appended(seen.appended),
    .out_inversion_flag(seen.inversion_flag), .out_overflow_cleared(seen.overflow_cleared),
    .out_dropped(seen.dropped), .out_entry_count(seen.entry_count),
    .out_read_valid(seen.read_valid), .out_read_module(seen.read_module),
    .out_read_task(seen.read_task), .out_read_event(seen.read_event),
    .out_read_time(seen.read_time),
    .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(seen);
  end

  task automatic send_item(trace_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_op <= c.op;
    in_module_id <= c.module_id;
    in_task_id <= c.task_id;
    in_event_code <= c.event_code;
    in_time_ms <= c.time_ms;
    in_read_offset <= c.read_offset;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(c);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    start <= 0;
    @(posedge clk);
    while (board.pending.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    start <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    cfg_we <= 0;
  endtask

  task automatic emit(int mid, int ev, logic [31:0] t, logic [7:0] tk = 8'h5A);
    trace_cmd_t c;
    c = '{etl_pkg::OP_EMIT, mid[3:0], tk, ev[7:0], t, 8'd0};
    send_item(c);
  endtask

  task automatic other_op(logic [1:0] op, logic [31:0] t, logic [7:0] off);
    trace_cmd_t c;
    c = '{op, 4'($urandom), 8'($urandom), 8'($urandom), t, off};
    send_item(c);
  endtask

  task automatic random_item();
    trace_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    clock_ms += $urandom_range(1, 3) == 1 ? $urandom_range(200) : $urandom_range(20);
    c.module_id = $urandom_range(3) == 0 ? 4'($urandom) : 4'($urandom_range(3));
    c.task_id = 8'($urandom);
    c.event_code = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(1, 6));
    c.time_ms = $urandom_range(19) == 0 ? $urandom : clock_ms;
    c.read_offset = $urandom_range(1) ? 8'($urandom_range(board.count + 2)) : 8'($urandom);
    if (pick < 65) c.op = etl_pkg::OP_EMIT;
    else if (pick < 75) begin
      c.op = etl_pkg::OP_DROP;
      c.time_ms = $urandom_range(9) == 0 ? $urandom : clock_ms - $urandom_range(400);
    end else if (pick < 77) c.op = etl_pkg::OP_CLEAR;
    else c.op = etl_pkg::OP_READ;
    send_item(c);
  endtask

  initial begin
    #20ms;
    $display("event_trace_logger_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, inversion, startup, repeat, window wrap
    emit(0, 5, 32'd10);
    emit(0, 5, 32'd50);
    emit(0, 5, 32'd200);
    emit(0, 3, 32'd300, 8'h80);
    emit(0, 1, 32'd310, 8'h7F);
    emit(15, 255, 32'hFFFF_FFFF, 8'hFF);
    emit(15, 255, 32'd20);
    emit(15, 0, 32'd40, 8'h00);
    other_op(etl_pkg::OP_READ, 0, 8'd0);
    other_op(etl_pkg::OP_READ, 0, 8'd3);
    other_op(etl_pkg::OP_READ, 0, 8'd255);
    other_op(etl_pkg::OP_DROP, 32'd50, 0);
    other_op(etl_pkg::OP_DROP, 32'd0, 0);
    other_op(etl_pkg::OP_CLEAR, 0, 0);
    other_op(etl_pkg::OP_READ, 0, 8'd0);
    settle();
    write_reg(etl_pkg::CFG_ENABLE, 0);
    emit(2, 9, 32'd1);
    write_reg(etl_pkg::CFG_ENABLE, 1);
    write_reg(etl_pkg::CFG_WINDOW, 32'hFFFF_FFFF);
    write_reg(etl_pkg::CFG_STARTUP, 8'd0);
    write_reg(etl_pkg::CFG_INVERSION, 8'd0);
    emit(2, 9, 32'd1);
    emit(2, 9, 32'hFFFF_FFF0);
    emit(2, 0, 32'd5);
    emit(2, 4, 32'd6);
    // fill past the limit to force overflow clears
    for (int i = 0; i < 270; i++) emit(i % 16, 200 + i % 50, 32'(1000 + i * 7), 8'(i));
    other_op(etl_pkg::OP_DROP, 32'hFFFF_FFFF, 0);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 76;
        2: idle_pct = 0;
        default: idle_pct = 36;
      endcase
      case (ph)
        0: write_reg(etl_pkg::CFG_WINDOW, 32'd0);
        1: write_reg(etl_pkg::CFG_WINDOW, 32'd100);
        2: write_reg(etl_pkg::CFG_STARTUP, 8'd255);
        3: write_reg(etl_pkg::CFG_INVERSION, 8'd128);
        4: write_reg(etl_pkg::CFG_ENABLE, 0);
        5: write_reg(etl_pkg::CFG_ENABLE, 1);
        6: write_reg(etl_pkg::CFG_WINDOW, $urandom);
        default: write_reg(etl_pkg::CFG_STARTUP, 8'd1);
      endcase
      for (int i = 0; i < (ph == 4 ? 40 : 140); i++) random_item();
      settle();
    end
    idle_pct = 0;

    if (board.pending.size() != 0) begin
      report_mismatch("missing item", 0, 32'(board.pending.size()));
    end
    if (error_count == 0) begin
      $display("event_trace_logger_unit regression: pass");
    end else begin
      $display("event_trace_logger_unit regression: fail");
    end
    $finish;
  end
endmodule
